// File: hw/rtl/short_name_converter_defines.svh
// ---------------------------------------------------------------------------
// short name converter assertion macros
// concurrent assertion helpers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef SHORT_NAME_CONVERTER_DEFINES_SVH
`define SHORT_NAME_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

`define SNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("short_name_converter assertion failed");

`define SNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("short_name_converter assertion failed");

`else

`define SNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/snc_pkg.sv
// ---------------------------------------------------------------------------
// snc_pkg
// shared constants, types and helpers of the short name converter
// ---------------------------------------------------------------------------
`default_nettype none

package snc_pkg;

  localparam int unsigned BaseLenDef = 8;
  localparam int unsigned ExtLenDef  = 3;
  localparam int unsigned PosMax     = 13;
  localparam int unsigned PosW       = 4;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2e;

  localparam logic [63:0] Spaces64 = {8{ChSpace}};
  localparam logic [23:0] Spaces24 = {3{ChSpace}};

  typedef struct packed {
    logic [63:0] base_chars;
    logic [23:0] ext_chars;
    logic        valid_res;
  } snc_result_t;

  function automatic logic is_keep(input logic [7:0] ch);
    logic upper;
    logic digit;
    upper = (ch >= 8'h41) && (ch <= 8'h5a);
    digit = (ch >= 8'h30) && (ch <= 8'h39);
    return upper || digit;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/snc_name_acc.sv
// ---------------------------------------------------------------------------
// snc_name_acc
// name accumulator: per-item state update and 8.3 result formation
// ---------------------------------------------------------------------------
`default_nettype none

module snc_name_acc #(
  parameter int unsigned BASE_LEN = snc_pkg::BaseLenDef,
  parameter int unsigned EXT_LEN  = snc_pkg::ExtLenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         ch_i,
  output snc_pkg::snc_result_t    result_o
);
  import snc_pkg::*;

  localparam int unsigned ScanLen  = BASE_LEN + EXT_LEN + 1;
  localparam int unsigned BaseCntW = $clog2(BASE_LEN + 1);
  localparam int unsigned ExtCntW  = $clog2(EXT_LEN + 1);

  logic [8*BASE_LEN-1:0] base_buf_q, base_buf_d;
  logic [8*EXT_LEN-1:0]  ext_buf_q, ext_buf_d;
  logic [BaseCntW-1:0]   base_cnt_q, base_cnt_d;
  logic [ExtCntW-1:0]    ext_cnt_q, ext_cnt_d;
  logic                  in_base_q, in_base_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  dots_only_q, dots_only_d;

  logic is_nul;
  logic is_dot;
  logic keep;

  assign is_nul = (ch_i == ChNul);
  assign is_dot = (ch_i == ChDot);
  assign keep   = is_keep(ch_i);

  always_comb begin
    base_buf_d  = base_buf_q;
    ext_buf_d   = ext_buf_q;
    base_cnt_d  = base_cnt_q;
    ext_cnt_d   = ext_cnt_q;
    in_base_d   = in_base_q;
    pos_d       = pos_q;
    dots_only_d = dots_only_q;
    if (step_i) begin
      if (is_nul) begin
        base_buf_d  = {BASE_LEN{ChSpace}};
        ext_buf_d   = {EXT_LEN{ChSpace}};
        base_cnt_d  = '0;
        ext_cnt_d   = '0;
        in_base_d   = 1'b1;
        pos_d       = '0;
        dots_only_d = 1'b1;
      end else begin
        if (!is_dot) begin
          dots_only_d = 1'b0;
        end
        if (pos_q < PosW'(ScanLen)) begin
          if (is_dot) begin
            in_base_d = 1'b0;
          end else if (keep) begin
            if (in_base_q) begin
              if (base_cnt_q < BaseCntW'(BASE_LEN)) begin
                for (int i = 0; i < BASE_LEN; i++) begin
                  if (base_cnt_q == BaseCntW'(i)) begin
                    base_buf_d[8*i +: 8] = ch_i;
                  end
                end
                base_cnt_d = base_cnt_q + 1'b1;
              end
            end else if (ext_cnt_q < ExtCntW'(EXT_LEN)) begin
              for (int j = 0; j < EXT_LEN; j++) begin
                if (ext_cnt_q == ExtCntW'(j)) begin
                  ext_buf_d[8*j +: 8] = ch_i;
                end
              end
              ext_cnt_d = ext_cnt_q + 1'b1;
            end
          end
        end
        if (pos_q < PosW'(PosMax)) begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_buf_q  <= {BASE_LEN{ChSpace}};
      ext_buf_q   <= {EXT_LEN{ChSpace}};
      base_cnt_q  <= '0;
      ext_cnt_q   <= '0;
      in_base_q   <= 1'b1;
      pos_q       <= '0;
      dots_only_q <= 1'b1;
    end else begin
      base_buf_q  <= base_buf_d;
      ext_buf_q   <= ext_buf_d;
      base_cnt_q  <= base_cnt_d;
      ext_cnt_q   <= ext_cnt_d;
      in_base_q   <= in_base_d;
      pos_q       <= pos_d;
      dots_only_q <= dots_only_d;
    end
  end

  // result as seen by a terminating nul
  always_comb begin
    result_o.base_chars                   = Spaces64;
    result_o.ext_chars                    = Spaces24;
    result_o.valid_res                    = (base_cnt_q != '0);
    result_o.base_chars[8*BASE_LEN-1:0]   = base_buf_q;
    result_o.ext_chars[8*EXT_LEN-1:0]     = ext_buf_q;
    if (dots_only_q && (pos_q == PosW'(1) || pos_q == PosW'(2))) begin
      result_o.base_chars    = Spaces64;
      result_o.base_chars[7:0] = ChDot;
      if (pos_q == PosW'(2) && BASE_LEN >= 2) begin
        result_o.base_chars[15:8] = ChDot;
      end
      result_o.ext_chars = Spaces24;
      result_o.valid_res = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/short_name_converter.sv
// ---------------------------------------------------------------------------
// short_name_converter
// builds a space-padded 8.3 short name from a nul-terminated byte stream
// ---------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------
//  in      | in_valid_i  | in_stall_o  | ch_i
//  out     | out_valid_o | out_stall_i | base_chars_o, ext_chars_o, valid_res_o
//
//  one item per cycle while in_stall_o is low; an item is held in the input
//  register, and a nul item's result then moves into the result register
//  reset empties both registers and loads an empty name
//  the input stalls only when a nul item waits behind a stalled result
// ---------------------------------------------------------------------------
`default_nettype none

`include "short_name_converter_defines.svh"

module short_name_converter #(
  parameter int unsigned BASE_LEN = snc_pkg::BaseLenDef,
  parameter int unsigned EXT_LEN  = snc_pkg::ExtLenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      base_chars_o,
  output logic [23:0]      ext_chars_o,
  output logic             valid_res_o
);
  import snc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  ch_q;
  logic        out_valid_q;
  snc_result_t res_q;
  snc_result_t acc_res;
  logic        stage_blocked;
  logic        step;
  logic        in_accept;
  logic        nul_q;

  assign nul_q         = (ch_q == ChNul);
  assign stage_blocked = in_valid_q && nul_q && out_valid_q && out_stall_i;
  assign step          = in_valid_q && !stage_blocked;
  assign in_stall_o    = stage_blocked;
  assign in_accept     = in_valid_i && !in_stall_o;

  snc_name_acc #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .ch_i     (ch_q),
    .result_o (acc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && nul_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && nul_q) begin
      res_q <= acc_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign base_chars_o = res_q.base_chars;
  assign ext_chars_o  = res_q.ext_chars;
  assign valid_res_o  = res_q.valid_res;

  `SNC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i && in_valid_q)
  `SNC_ASSERT_NEXT(a_nul_gives_item, clk_i, rst_ni, step && nul_q, out_valid_o)
  `SNC_ASSERT_NOW(a_unusable_blank, clk_i, rst_ni, out_valid_o && !valid_res_o, base_chars_o == Spaces64)

endmodule

`default_nettype wire
